@@ src/mhfs_pkg.sv @@
// shared types and constants for the magic header frame sync block
package mhfs_pkg;

    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 32;
    localparam int MAGIC_W        = 32;
    localparam int WINDOW_BYTES   = 8;
    localparam int WINDOW_W       = WINDOW_BYTES * BYTE_W;
    localparam int FILL_W         = 4;
    localparam int HDR_IDX_W      = 6;
    localparam int LENGTH_BITS_DEFAULT = 32;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = HDR_IDX_W'(35);
    localparam logic [HDR_IDX_W-1:0] SYNC_IDX  = HDR_IDX_W'(WINDOW_BYTES);
    localparam logic [HDR_IDX_W-1:0] LEN_FIRST = HDR_IDX_W'(24);
    localparam logic [HDR_IDX_W-1:0] LEN_LAST  = HDR_IDX_W'(27);
    localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(WINDOW_BYTES);
    localparam logic [31:0]          MSG_TYPE_DATA = 32'd1;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAGIC = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_HUNT    = 2'd0,
        ROLE_SYNC    = 2'd1,
        ROLE_HEADER  = 2'd2,
        ROLE_PAYLOAD = 2'd3
    } role_t;

    typedef struct packed {
        role_t                byte_role;
        logic                 frame_end;
        logic [COUNT_W-1:0]   frame_count;
    } result_t;

endpackage

@@ src/mhfs_apb_regs.sv @@
// apb configuration register holding the expected magic word
module mhfs_apb_regs
    import mhfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [MAGIC_W-1:0]    magic_word
);

    logic [MAGIC_W-1:0] magic_reg;
    logic [MAGIC_W-1:0] magic_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAGIC);

    always_comb begin
        magic_next = magic_reg;
        if (wr_en) begin
            magic_next = pwdata[MAGIC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= '0;
        end else begin
            magic_reg <= magic_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAGIC) begin
            prdata = APB_DATA_W'(magic_reg);
        end
    end

    assign magic_word = magic_reg;

endmodule

@@ src/mhfs_core.sv @@
// frame sync state and the per-byte next-state and result logic
module mhfs_core
    import mhfs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [MAGIC_W-1:0] magic_word,
    output result_t            result
);

    phase_t                 phase_reg, phase_next;
    logic [WINDOW_W-1:0]    window_reg, window_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [COUNT_W-1:0]     frames_reg, frames_next;

    logic [WINDOW_W-1:0]    shifted_window;
    logic [31:0]            len_byte;
    logic [1:0]             len_pos;
    role_t                  role;
    logic                   fend;

    assign shifted_window = {data_byte, window_reg[WINDOW_W-1:BYTE_W]};
    assign len_pos        = 2'(hdr_idx_reg - LEN_FIRST);
    assign len_byte       = 32'(data_byte) << {len_pos, 3'b000};

    always_comb begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        fill_next    = fill_reg;
        hdr_idx_next = hdr_idx_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        frames_next  = frames_reg;
        role         = ROLE_HUNT;
        fend         = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                role = ROLE_HEADER;
                if (hdr_idx_reg >= LEN_FIRST && hdr_idx_reg <= LEN_LAST) begin
                    length_next = length_reg | len_byte[LENGTH_BITS-1:0];
                end
                hdr_idx_next = hdr_idx_reg + 1'b1;
                if (hdr_idx_reg == HDR_LAST) begin
                    if (length_next == '0) begin
                        // empty payload: frame closes on the last header byte
                        fend         = 1'b1;
                        frames_next  = frames_reg + 1'b1;
                        phase_next   = PH_HUNT;
                        window_next  = '0;
                        fill_next    = '0;
                        hdr_idx_next = '0;
                        remain_next  = '0;
                    end else begin
                        remain_next = length_next;
                        phase_next  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                if (remain_reg <= LENGTH_BITS'(1)) begin
                    fend         = 1'b1;
                    frames_next  = frames_reg + 1'b1;
                    phase_next   = PH_HUNT;
                    window_next  = '0;
                    fill_next    = '0;
                    hdr_idx_next = '0;
                    remain_next  = '0;
                end else begin
                    remain_next = remain_reg - 1'b1;
                end
            end
            default: begin
                phase_next  = PH_HUNT;
                window_next = shifted_window;
                if (fill_reg < FILL_FULL) begin
                    fill_next = fill_reg + 1'b1;
                end
                if (fill_next >= FILL_FULL
                    && shifted_window[31:0] == MSG_TYPE_DATA
                    && shifted_window[WINDOW_W-1:32] == magic_word) begin
                    role         = ROLE_SYNC;
                    phase_next   = PH_HEADER;
                    hdr_idx_next = SYNC_IDX;
                    length_next  = '0;
                    remain_next  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            window_reg  <= '0;
            fill_reg    <= '0;
            hdr_idx_reg <= '0;
            length_reg  <= '0;
            remain_reg  <= '0;
            frames_reg  <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            hdr_idx_reg <= hdr_idx_next;
            length_reg  <= length_next;
            remain_reg  <= remain_next;
            frames_reg  <= frames_next;
        end
    end

    assign result.byte_role   = role;
    assign result.frame_end   = fend;
    assign result.frame_count = frames_next;

endmodule

@@ src/magic_header_frame_sync_top.sv @@
// top level of the magic header frame sync block
//
// byte-serial frame synchronizer. each input item is one byte of a received
// stream; each byte produces exactly one result item giving its role (hunting,
// sync found, header rest, payload), a frame end flag and the running frame
// count. the block hunts for an 8-byte window whose first little-endian word
// is 1 and whose second equals the magic_word register (apb address 0), then
// walks the 36-byte header, takes the payload length from header bytes 24..27
// (low LENGTH_BITS bits), skips the payload and flags the last byte of the
// frame. throughput is one byte per clock unless m_ready holds off a result;
// each result passes through the input register and then the result register,
// which is loaded in the same step as the state update. the input register
// accepts a new item while a result waits for m_ready, so the link side only
// stalls when both registers are full.
// magic_word should be written while idle.
module magic_header_frame_sync_top
    import mhfs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // byte input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_byte_role,
    output logic                  m_frame_end,
    output logic [COUNT_W-1:0]    m_frame_count
);

    logic [MAGIC_W-1:0] magic_word;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    result_t            core_result;

    logic               advance;
    logic               in_accept;

    mhfs_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .magic_word (magic_word)
    );

    // byte moves from input register into state and result register
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign in_accept = s_valid && s_ready;

    mhfs_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .magic_word (magic_word),
        .result     (core_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= s_data_byte;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_byte_role   = out_reg.byte_role;
    assign m_frame_end   = out_reg.frame_end;
    assign m_frame_count = out_reg.frame_count;

endmodule
